// ----- rtl/mbpe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbpe_pkg: shared types and helpers for the mono bitmap pixel expander
// Register indexes, configuration record, queue entry and bit helpers.
// ----------------------------------------------------------------------------
package mbpe_pkg;

   localparam int unsigned MAX_WIDTH  = 255;
   localparam int unsigned MAX_HEIGHT = 255;
   localparam int unsigned BYTE_BITS  = 8;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

   localparam logic [7:0] MAX_WIDTH_C  = 8'(MAX_WIDTH);
   localparam logic [7:0] MAX_HEIGHT_C = 8'(MAX_HEIGHT);

   // register reset values
   localparam logic [15:0] FG_RESET     = 16'hFFFF;
   localparam logic [15:0] BG_RESET     = 16'h0000;
   localparam logic [7:0]  WIDTH_RESET  = 8'd8;
   localparam logic [7:0]  HEIGHT_RESET = 8'd1;
   localparam logic        OPAQUE_RESET = 1'b1;
   localparam logic [9:0]  ORIGIN_RESET = 10'd0;

   typedef enum logic [2:0] {
      REG_FG_COLOR     = 3'd0,
      REG_BG_COLOR     = 3'd1,
      REG_WIDTH_PIXELS = 3'd2,
      REG_HEIGHT_ROWS  = 3'd3,
      REG_OPAQUE_MODE  = 3'd4,
      REG_ORIGIN_X     = 3'd5,
      REG_ORIGIN_Y     = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [15:0] fg_color;
      logic [15:0] bg_color;
      logic [7:0]  width_pixels;
      logic [7:0]  height_rows;
      logic        opaque_mode;
      logic [9:0]  origin_x;
      logic [9:0]  origin_y;
   } cfg_type;

   // one classified byte waiting for expansion
   typedef struct packed {
      logic [7:0]  data;
      logic [7:0]  mask;     // pixels still to emit
      logic [10:0] base_x;
      logic [10:0] y;
      logic        img_end;
   } cmd_type;

   // low n bits set, n == 0 means all eight
   function automatic logic [7:0] low_mask(input logic [2:0] n);
      logic [7:0] m;
      for (int i = 0; i < BYTE_BITS; i++) begin
         m[i] = (n == 3'd0) || (i < int'(n));
      end
      return m;
   endfunction

   // index of lowest set bit
   function automatic logic [2:0] lowest_bit(input logic [7:0] m);
      logic [2:0] k;
      k = 3'd0;
      for (int i = BYTE_BITS - 1; i >= 0; i--) begin
         if (m[i]) begin
            k = 3'(i);
         end
      end
      return k;
   endfunction

endpackage

// ----- rtl/mbpe_if.sv -----
// ----------------------------------------------------------------------------
// mbpe_if: valid/ready channels of the pixel expander
// Byte request channel and pixel response channel.
// ----------------------------------------------------------------------------
interface mbpe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] bitmap_byte;
   logic       image_start;

   modport source (output valid, output bitmap_byte, output image_start, input ready);
   modport sink   (input valid, input bitmap_byte, input image_start, output ready);
endinterface

interface mbpe_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_color;
   logic [10:0] pixel_x;
   logic [10:0] pixel_y;
   logic        last_of_byte;
   logic        image_end;

   modport source (output valid, output pixel_color, output pixel_x, output pixel_y,
                   output last_of_byte, output image_end, input ready);
   modport sink   (input valid, input pixel_color, input pixel_x, input pixel_y,
                   input last_of_byte, input image_end, output ready);
endinterface

// ----- rtl/mbpe_cfg.sv -----
// ----------------------------------------------------------------------------
// mbpe_cfg: configuration registers
// Write-only register file, unknown indexes are dropped.
// ----------------------------------------------------------------------------
module mbpe_cfg (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   output mbpe_pkg::cfg_type cfg
);
   import mbpe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (reg_index_type'(csr_index))
            REG_FG_COLOR:     cfg_in.fg_color     = csr_wdata;
            REG_BG_COLOR:     cfg_in.bg_color     = csr_wdata;
            REG_WIDTH_PIXELS: cfg_in.width_pixels = csr_wdata[7:0];
            REG_HEIGHT_ROWS:  cfg_in.height_rows  = csr_wdata[7:0];
            REG_OPAQUE_MODE:  cfg_in.opaque_mode  = csr_wdata[0];
            REG_ORIGIN_X:     cfg_in.origin_x     = csr_wdata[9:0];
            REG_ORIGIN_Y:     cfg_in.origin_y     = csr_wdata[9:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fg_color     <= FG_RESET;
         cfg_ff.bg_color     <= BG_RESET;
         cfg_ff.width_pixels <= WIDTH_RESET;
         cfg_ff.height_rows  <= HEIGHT_RESET;
         cfg_ff.opaque_mode  <= OPAQUE_RESET;
         cfg_ff.origin_x     <= ORIGIN_RESET;
         cfg_ff.origin_y     <= ORIGIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/mbpe_front.sv -----
// ----------------------------------------------------------------------------
// mbpe_front: byte classifier
// Tracks row and byte position, picks the pixels a byte emits and queues it.
// ----------------------------------------------------------------------------
module mbpe_front (
   input  logic              clock,
   input  logic              reset,
   input  mbpe_pkg::cfg_type cfg,
   mbpe_req_if.sink          req,
   input  logic              q_full,
   output logic              q_push,
   output mbpe_pkg::cmd_type q_cmd
);
   import mbpe_pkg::*;

   logic [4:0] col_ff, col_in;
   logic [7:0] row_ff, row_in;

   logic [7:0] w_eff, h_eff, last_row;
   logic [8:0] w_round;
   logic [4:0] last_col;
   logic [4:0] col_cur;
   logic [7:0] row_cur;
   logic       row_done, img_done, accept;
   logic [2:0] tail_bits;
   logic [7:0] mask;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   // geometry
   always_comb begin
      w_eff    = (cfg.width_pixels == 8'd0) || (cfg.width_pixels > MAX_WIDTH_C)
                 ? MAX_WIDTH_C : cfg.width_pixels;
      h_eff    = (cfg.height_rows == 8'd0) || (cfg.height_rows > MAX_HEIGHT_C)
                 ? MAX_HEIGHT_C : cfg.height_rows;
      w_round  = {1'b0, w_eff} + 9'd7;
      last_col = 5'(w_round[8:3] - 6'd1);
      last_row = h_eff - 8'd1;
   end

   // position and pixel selection
   always_comb begin
      col_cur   = req.image_start ? 5'd0 : col_ff;
      row_cur   = req.image_start ? 8'd0 : row_ff;
      row_done  = col_cur >= last_col;
      img_done  = row_done && (row_cur >= last_row);
      tail_bits = row_done ? w_eff[2:0] : 3'd0;
      mask      = low_mask(tail_bits) & (cfg.opaque_mode ? 8'hFF : req.bitmap_byte);

      q_cmd.data    = req.bitmap_byte;
      q_cmd.mask    = mask;
      q_cmd.base_x  = {1'b0, cfg.origin_x} + {3'b000, col_cur, 3'b000};
      q_cmd.y       = {1'b0, cfg.origin_y} + {3'b000, row_cur};
      q_cmd.img_end = img_done;
      q_push        = accept && (mask != 8'd0);
   end

   // counter advance
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_done) begin
            col_in = 5'd0;
            row_in = img_done ? 8'd0 : row_cur + 8'd1;
         end else begin
            col_in = col_cur + 5'd1;
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 5'd0;
         row_ff <= 8'd0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ----- rtl/mbpe_fifo.sv -----
// ----------------------------------------------------------------------------
// mbpe_fifo: command queue
// Short register queue between the classifier and the pixel emitter.
// ----------------------------------------------------------------------------
module mbpe_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mbpe_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output mbpe_pkg::cmd_type head_cmd
);
   import mbpe_pkg::*;

   cmd_type                 entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_PTR_W:0]     cnt_ff, cnt_in;

   assign full       = cnt_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_cmd   = entry_ff[rd_ff];

   // pointers and fill level
   always_comb begin
      wr_in  = push ? wr_ff + FIFO_PTR_W'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + FIFO_PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + (FIFO_PTR_W+1)'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - (FIFO_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/mbpe_back.sv -----
// ----------------------------------------------------------------------------
// mbpe_back: pixel emitter
// Walks the pixel mask of each queued byte, one pixel per cycle while rsp is ready.
// ----------------------------------------------------------------------------
module mbpe_back (
   input  logic              clock,
   input  logic              reset,
   input  mbpe_pkg::cfg_type cfg,
   input  logic              q_valid,
   input  mbpe_pkg::cmd_type q_cmd,
   output logic              q_pop,
   mbpe_rsp_if.source        rsp
);
   import mbpe_pkg::*;

   cmd_type     act_ff, act_in;
   logic        act_valid_ff, act_valid_in;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] color_ff, color_in;
   logic [10:0] x_ff, x_in, y_ff, y_in;
   logic        last_ff, last_in, end_ff, end_in;

   cmd_type     cur;
   logic        cur_valid, out_free, fire;
   logic [2:0]  k;
   logic [7:0]  rem;

   // pick the byte in work, held one first
   always_comb begin
      cur       = act_valid_ff ? act_ff : q_cmd;
      cur_valid = act_valid_ff || q_valid;
      out_free  = !out_valid_ff || rsp.ready;
      fire      = cur_valid && out_free;
      k         = lowest_bit(cur.mask);
      rem       = cur.mask & ~(8'h01 << k);
      q_pop     = fire && !act_valid_ff;
   end

   // held byte and output word
   always_comb begin
      act_in       = act_ff;
      act_valid_in = act_valid_ff;
      out_valid_in = out_free ? cur_valid : out_valid_ff;
      color_in     = color_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      last_in      = last_ff;
      end_in       = end_ff;
      if (fire) begin
         act_in       = cur;
         act_in.mask  = rem;
         act_valid_in = rem != 8'd0;
         color_in     = cur.data[k] ? cfg.fg_color : cfg.bg_color;
         x_in         = cur.base_x + {8'd0, k};
         y_in         = cur.y;
         last_in      = rem == 8'd0;
         end_in       = cur.img_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         act_valid_ff <= act_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      color_ff <= color_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      last_ff  <= last_in;
      end_ff   <= end_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.pixel_color  = color_ff;
   assign rsp.pixel_x      = x_ff;
   assign rsp.pixel_y      = y_ff;
   assign rsp.last_of_byte = last_ff;
   assign rsp.image_end    = end_ff;

endmodule

// ----- rtl/mono_bitmap_pixel_expander.sv -----
// A byte's first pixel passes the command queue and the output register before rsp.
// Throughput: one pixel per cycle while rsp is ready; a byte emits 1 to 8 pixels
//   and the emitter's single output register sets this pace.
// A transparent byte with no set pixels is accepted and emits nothing.
// Four-entry queue lets requests run ahead of a stalled response side.
// Reset (synchronous): counters and queue cleared, registers at their defaults.
// ----------------------------------------------------------------------------
// mono_bitmap_pixel_expander: 1bpp bitmap to RGB565 pixel stream
// Classifier, command queue and pixel emitter with a write-only register file.
// ----------------------------------------------------------------------------
module mono_bitmap_pixel_expander (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   mbpe_req_if.sink    req_bus,
   mbpe_rsp_if.source  rsp_bus
);
   import mbpe_pkg::*;

   cfg_type cfg;
   cmd_type push_cmd, head_cmd;
   logic    push, full, pop, head_valid;

   mbpe_cfg u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   mbpe_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req    (req_bus),
      .q_full (full),
      .q_push (push),
      .q_cmd  (push_cmd)
   );

   mbpe_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   mbpe_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (head_valid),
      .q_cmd   (head_cmd),
      .q_pop   (pop),
      .rsp     (rsp_bus)
   );

endmodule

// ----- rtl/mbpe_checker.sv -----
// ----------------------------------------------------------------------------
// mbpe_checker: port-level checks for the pixel expander
// Watches the response channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module mbpe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_pixel_color,
   input logic [10:0] rsp_pixel_x,
   input logic [10:0] rsp_pixel_y,
   input logic        rsp_last_of_byte,
   input logic        rsp_image_end
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_color)
         && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)
         && $stable(rsp_last_of_byte) && $stable(rsp_image_end))
      else $error("stalled response changed");

   // pixels of one byte follow without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_byte |=> rsp_valid)
      else $error("gap inside a byte");

   // within a byte, same row, columns move right
   a_byte_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_byte |=>
         rsp_pixel_y == $past(rsp_pixel_y) && rsp_pixel_x > $past(rsp_pixel_x)
         && rsp_image_end == $past(rsp_image_end))
      else $error("pixel order broken inside a byte");

endmodule

bind mono_bitmap_pixel_expander mbpe_checker u_mbpe_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_pixel_color  (rsp_bus.pixel_color),
   .rsp_pixel_x      (rsp_bus.pixel_x),
   .rsp_pixel_y      (rsp_bus.pixel_y),
   .rsp_last_of_byte (rsp_bus.last_of_byte),
   .rsp_image_end    (rsp_bus.image_end)
);

// ----- bench/mono_bitmap_pixel_expander_tb.sv -----
// ----------------------------------------------------------------------------
// mono_bitmap_pixel_expander_tb: self-checking bench for the pixel expander
// Feeds packed bitmap bytes through the request channel and predicts every
// RGB565 pixel in a behavioral model kept in step with the register writes.
// Pixels that come back are checked field by field, in order. Directed tests
// cover reset defaults, both modes, oversize and changed geometry, and register
// masking. A random phase runs mostly whole images with noise, random idles and stalls.
// ----------------------------------------------------------------------------
module mono_bitmap_pixel_expander_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mbpe_pkg::*;

   localparam logic [2:0]  REG_UNUSED    = 3'd7;
   localparam int unsigned DRAIN_CYCLES  = 12;
   localparam int unsigned LIMIT_CYCLES  = 200000;
   localparam int unsigned RANDOM_ITEMS  = 130;
   localparam int unsigned QUIET_ITEMS   = 40;
   localparam int unsigned IDLE_PERCENT  = 19;
   localparam int unsigned HOLD_CYCLES   = 80;

   // one expected pixel word
   typedef struct packed {
      logic [15:0] color;
      logic [10:0] x;
      logic [10:0] y;
      logic        last_of_byte;
      logic        image_end;
   } pixel_type;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   mbpe_req_if req_ch ();
   mbpe_rsp_if rsp_ch ();

   mono_bitmap_pixel_expander DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_bus      (req_ch),
      .rsp_bus      (rsp_ch)
   );

   // model state: register mirror and position counters
   cfg_type      regs;
   logic [4:0]   col_ctr;
   logic [7:0]   row_ctr;

   pixel_type    pending_pixels [$];
   int unsigned  fail_count;
   int unsigned  cycle_count;
   bit           quiet;
   int unsigned  hold_request;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d pixels outstanding", $time, pending_pixels.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   task automatic mirror_write(input logic [2:0] idx, input logic [15:0] value);
      case (idx)
         REG_FG_COLOR:     regs.fg_color     = value;
         REG_BG_COLOR:     regs.bg_color     = value;
         REG_WIDTH_PIXELS: regs.width_pixels = value[7:0];
         REG_HEIGHT_ROWS:  regs.height_rows  = value[7:0];
         REG_OPAQUE_MODE:  regs.opaque_mode  = value[0];
         REG_ORIGIN_X:     regs.origin_x     = value[9:0];
         REG_ORIGIN_Y:     regs.origin_y     = value[9:0];
         default: ;
      endcase
   endtask

   // expand one accepted byte into its expected pixels and advance the counters
   task automatic expand_byte(input logic [7:0] data, input logic start);
      int unsigned w, h, cols, nbits, n;
      bit          row_done, img_done;
      pixel_type   pix [8];
      if (start) begin
         col_ctr = '0;
         row_ctr = '0;
      end
      w = int'(regs.width_pixels);
      if (w == 0 || w > MAX_WIDTH) w = MAX_WIDTH;
      h = int'(regs.height_rows);
      if (h == 0 || h > MAX_HEIGHT) h = MAX_HEIGHT;
      cols = (w + 7) / 8;
      // counters past the current geometry count as last byte / last row
      row_done = int'(col_ctr) >= cols - 1;
      img_done = row_done && (int'(row_ctr) >= h - 1);
      nbits = (row_done && (w % 8) != 0) ? w % 8 : 8;
      n = 0;
      for (int k = 0; k < nbits; k++) begin
         if (regs.opaque_mode || data[k]) begin
            pix[n].color        = data[k] ? regs.fg_color : regs.bg_color;
            pix[n].x            = 11'(int'(regs.origin_x) + int'(col_ctr) * 8 + k);
            pix[n].y            = 11'(int'(regs.origin_y) + int'(row_ctr));
            pix[n].last_of_byte = 1'b0;
            pix[n].image_end    = img_done;
            n++;
         end
      end
      // empty transparent byte: nothing emitted, counters still move
      if (n > 0) pix[n-1].last_of_byte = 1'b1;
      for (int i = 0; i < n; i++) pending_pixels.push_back(pix[i]);
      if (row_done) begin
         col_ctr = '0;
         row_ctr = img_done ? 8'd0 : row_ctr + 8'd1;
      end else begin
         col_ctr = col_ctr + 5'd1;
      end
   endtask

   // ---------------------------------------------------------------- drivers

   // one register write per edge; caller drops the enable after the last one
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      mirror_write(idx, value);
   endtask

   // full register set, junk in the unused upper bits to check masking
   task automatic program_regs(input cfg_type c);
      write_reg(REG_FG_COLOR, c.fg_color);
      write_reg(REG_BG_COLOR, c.bg_color);
      write_reg(REG_WIDTH_PIXELS, {8'($urandom), c.width_pixels});
      write_reg(REG_HEIGHT_ROWS, {8'($urandom), c.height_rows});
      write_reg(REG_OPAQUE_MODE, {15'($urandom), c.opaque_mode});
      write_reg(REG_ORIGIN_X, {6'($urandom), c.origin_x});
      write_reg(REG_ORIGIN_Y, {6'($urandom), c.origin_y});
      csr_write_en <= 1'b0;
   endtask

   // offer one word; valid stays up after acceptance unless the next call idles
   task automatic send_byte(input logic [7:0] data, input logic start);
      if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.bitmap_byte <= data;
      req_ch.image_start <= start;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expand_byte(data, start);
   endtask

   // wait until every pixel is back, then hold the request side idle before going on
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // receiver: random stalls, quiet stretches, and a long hold when asked
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (quiet) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // ---------------------------------------------------------------- checker

   task automatic report_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
               $time, name, want_v, got_v);
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected pixel, expected none actual color 0x%0h x %0d y %0d",
                     $time, rsp_ch.pixel_color, rsp_ch.pixel_x, rsp_ch.pixel_y);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_ch.pixel_color !== want.color)
               report_field("pixel_color", want.color, rsp_ch.pixel_color);
            if (rsp_ch.pixel_x !== want.x)
               report_field("pixel_x", want.x, rsp_ch.pixel_x);
            if (rsp_ch.pixel_y !== want.y)
               report_field("pixel_y", want.y, rsp_ch.pixel_y);
            if (rsp_ch.last_of_byte !== want.last_of_byte)
               report_field("last_of_byte", want.last_of_byte, rsp_ch.last_of_byte);
            if (rsp_ch.image_end !== want.image_end)
               report_field("image_end", want.image_end, rsp_ch.image_end);
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // defaults after reset: 8 wide, 1 row, opaque, white on black
   task automatic test_reset_defaults();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b0);
   endtask

   // opaque, short last byte, origins at their maximum, colors at extremes
   task automatic test_opaque_geometry();
      cfg_type c;
      wait_idle();
      c = '{fg_color: 16'h0000, bg_color: 16'hFFFF, width_pixels: 8'd10, height_rows: 8'd2,
            opaque_mode: 1'b1, origin_x: 10'd1023, origin_y: 10'd1023};
      program_regs(c);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h03, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFE, 1'b0);
   endtask

   // transparent: empty byte gives nothing but still moves the counters
   task automatic test_transparent();
      cfg_type c;
      wait_idle();
      c = '{fg_color: 16'hF800, bg_color: 16'h07E0, width_pixels: 8'd8, height_rows: 8'd2,
            opaque_mode: 1'b0, origin_x: 10'd100, origin_y: 10'd50};
      program_regs(c);
      send_byte(8'h00, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h5A, 1'b0);
   endtask

   // zero width and height fall back to the maximum; start restarts mid-row
   task automatic test_oversize_geometry();
      cfg_type c;
      wait_idle();
      c = '{fg_color: 16'h001F, bg_color: 16'hAAAA, width_pixels: 8'd0, height_rows: 8'd0,
            opaque_mode: 1'b1, origin_x: 10'd0, origin_y: 10'd0};
      program_regs(c);
      send_byte(8'hC3, 1'b1);
      send_byte(8'h3C, 1'b0);
      send_byte(8'h81, 1'b1);
   endtask

   // geometry shrinks mid-image: counters beyond the new last byte / last row
   task automatic test_geometry_change();
      wait_idle();
      write_reg(REG_WIDTH_PIXELS, 16'd24);
      write_reg(REG_HEIGHT_ROWS, 16'd4);
      csr_write_en <= 1'b0;
      send_byte(8'h11, 1'b1);
      send_byte(8'h22, 1'b0);
      wait_idle();
      write_reg(REG_WIDTH_PIXELS, 16'd8);
      write_reg(REG_HEIGHT_ROWS, 16'd1);
      csr_write_en <= 1'b0;
      send_byte(8'h33, 1'b0);
      wait_idle();
      write_reg(REG_HEIGHT_ROWS, 16'd5);
      csr_write_en <= 1'b0;
      send_byte(8'h01, 1'b1);
      send_byte(8'h02, 1'b0);
      send_byte(8'h04, 1'b0);
      wait_idle();
      write_reg(REG_HEIGHT_ROWS, 16'd2);
      csr_write_en <= 1'b0;
      send_byte(8'h08, 1'b0);
      send_byte(8'h10, 1'b0);
   endtask

   // unknown index ignored, upper data bits dropped
   task automatic test_register_masking();
      wait_idle();
      write_reg(REG_UNUSED, 16'h1234);
      write_reg(REG_WIDTH_PIXELS, 16'hAB03);
      write_reg(REG_OPAQUE_MODE, 16'hFFFE);
      write_reg(REG_ORIGIN_X, 16'hFC05);
      csr_write_en <= 1'b0;
      send_byte(8'h07, 1'b1);
      send_byte(8'hF9, 1'b0);
   endtask

   // receiver holds off while the sender keeps going, so the queue fills
   task automatic test_backpressure();
      cfg_type c;
      wait_idle();
      c = '{fg_color: 16'h1234, bg_color: 16'hFEDC, width_pixels: 8'd8, height_rows: 8'd4,
            opaque_mode: 1'b1, origin_x: 10'd512, origin_y: 10'd256};
      program_regs(c);
      quiet = 1'b1;
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 16; i++) send_byte(8'($urandom), i == 0);
      quiet = 1'b0;
   endtask

   function automatic logic [9:0] pick_origin();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 15) return 10'd0;
      if (r < 30) return 10'd1023;
      return 10'($urandom);
   endfunction

   function automatic logic [15:0] pick_color();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return 16'h0000;
      if (r < 20) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // random images: mostly whole, well-formed images; some with stray starts
   task automatic test_random_images();
      cfg_type     c;
      int unsigned sent, r, w, h, cols, rows, nbytes;
      bit          noisy, start;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         quiet = (sent < QUIET_ITEMS);
         c.fg_color    = pick_color();
         c.bg_color    = pick_color();
         c.opaque_mode = 1'($urandom);
         c.origin_x    = pick_origin();
         c.origin_y    = pick_origin();
         r = $urandom_range(99);
         if (r < 60)      c.width_pixels = 8'($urandom_range(1, 24));
         else if (r < 75) c.width_pixels = 8'($urandom_range(25, 64));
         else if (r < 88) c.width_pixels = ($urandom_range(1)) ? 8'd255 : 8'd1;
         else if (r < 93) c.width_pixels = 8'd0;
         else             c.width_pixels = 8'($urandom_range(1, 255));
         r = $urandom_range(99);
         if (r < 70)      c.height_rows = 8'($urandom_range(1, 3));
         else if (r < 85) c.height_rows = 8'($urandom_range(4, 8));
         else             c.height_rows = ($urandom_range(1)) ? 8'd255 : 8'd0;
         program_regs(c);
         w = (c.width_pixels == 0) ? MAX_WIDTH : c.width_pixels;
         h = (c.height_rows == 0) ? MAX_HEIGHT : c.height_rows;
         cols = (w + 7) / 8;
         rows = (h > 3) ? $urandom_range(1, 3) : h * $urandom_range(1, 2);
         nbytes = cols * rows;
         if (nbytes > 40) nbytes = 40;
         noisy = ($urandom_range(99) < 25);
         for (int i = 0; i < nbytes; i++) begin
            if (noisy) start = ($urandom_range(99) < 15);
            else       start = (i == 0);
            send_byte(8'($urandom), start);
            sent++;
         end
      end
      quiet = 1'b0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.bitmap_byte = '0;
      req_ch.image_start = 1'b0;
      fail_count         = 0;
      cycle_count        = 0;
      quiet              = 1'b0;
      hold_request       = 0;
      regs = '{fg_color: FG_RESET, bg_color: BG_RESET, width_pixels: WIDTH_RESET,
               height_rows: HEIGHT_RESET, opaque_mode: OPAQUE_RESET,
               origin_x: ORIGIN_RESET, origin_y: ORIGIN_RESET};
      col_ctr = '0;
      row_ctr = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_opaque_geometry();
      test_transparent();
      test_oversize_geometry();
      test_geometry_change();
      test_register_masking();
      test_backpressure();
      test_random_images();

      wait_idle();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
